// ----- sv/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: phase codes, result codes,
// queue entry type and sizing constants. No dependencies.
`default_nettype none
package wsd_pkg;

    localparam int CAP_BITS = 16;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] OPC_MASK_LO = 4'hF;
    localparam logic [3:0] OPC_TEXT    = 4'd1;
    localparam logic [3:0] OPC_BINARY  = 4'd2;
    localparam logic [3:0] OPC_CLOSE   = 4'd8;
    localparam logic [3:0] OPC_PING    = 4'd9;

    localparam logic [7:0] PONG_FIRST    = 8'h8A;
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_CODE_16   = 7'd126;
    localparam logic [3:0] EXT_BYTES_16  = 4'd2;
    localparam logic [3:0] EXT_BYTES_64  = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ECHO    = 3'd5,
        PH_SKIP    = 3'd6
    } t_phase;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PONG    = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CLOSE     = 3'd1;
    localparam logic [2:0] ST_PING      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    typedef struct packed {
        logic        has_byte;
        logic [1:0]  byte_kind;
        logic [7:0]  data;
        logic        has_status;
        logic [2:0]  status;
        logic [31:0] len;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
    } t_entry;

endpackage
`default_nettype wire

// ----- sv/wsd_front.sv -----
// Front end of the deframer: header parser, unmasking and capacity check.
// Builds one queue entry per byte that causes results. Depends on wsd_pkg.
`default_nettype none
module wsd_front import wsd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_BITS-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic                i_frame_end,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output t_entry                   o_entry
);

    t_phase              r_phase, n_phase;
    logic [7:0]          r_fh, n_fh;
    logic [7:0]          r_sh, n_sh;
    logic [31:0]         r_len, n_len;
    logic [3:0]          r_hbc, n_hbc;
    logic [31:0]         r_key, n_key;
    logic [CAP_BITS-1:0] r_pc, n_pc;
    logic [31:0]         r_rc, n_rc;
    logic [CAP_BITS-1:0] r_dst_capacity;
    logic                accept;
    t_entry              ent;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic [3:0] hbc_inc;
        logic [3:0] need;
        logic [3:0] opc;
        logic [7:0] key_b;
        hbc_inc = r_hbc + 4'd1;
        need    = (r_sh[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
        opc     = r_fh[3:0];
        key_b   = 8'd0;
        n_phase = r_phase;
        n_fh    = r_fh;
        n_sh    = r_sh;
        n_len   = r_len;
        n_hbc   = r_hbc;
        n_key   = r_key;
        n_pc    = r_pc;
        n_rc    = r_rc + 32'd1;
        ent     = '0;

        case (r_phase)
            PH_SECOND: begin
                n_sh = i_rx_byte;
                if (opc == OPC_PING) begin
                    ent.has_byte  = 1'b1;
                    ent.byte_kind = KIND_PONG;
                    ent.data      = i_rx_byte;
                    n_phase       = PH_ECHO;
                end else if (opc == OPC_TEXT || opc == OPC_BINARY) begin
                    if (i_rx_byte[6:0] <= LEN_SHORT_MAX) begin
                        n_len   = {25'd0, i_rx_byte[6:0]};
                        n_hbc   = 4'd0;
                        n_phase = i_rx_byte[7] ? PH_MASK : PH_PAYLOAD;
                    end else begin
                        n_len   = 32'd0;
                        n_hbc   = 4'd0;
                        n_phase = PH_EXTLEN;
                    end
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[23:0], i_rx_byte};
                n_hbc = hbc_inc;
                if (hbc_inc >= need) begin
                    n_hbc   = 4'd0;
                    n_phase = r_sh[7] ? PH_MASK : PH_PAYLOAD;
                end
            end
            PH_MASK: begin
                case (r_hbc[1:0])
                    2'd0:    n_key[7:0]   = r_key[7:0]   | i_rx_byte;
                    2'd1:    n_key[15:8]  = r_key[15:8]  | i_rx_byte;
                    2'd2:    n_key[23:16] = r_key[23:16] | i_rx_byte;
                    default: n_key[31:24] = r_key[31:24] | i_rx_byte;
                endcase
                n_hbc = hbc_inc;
                if (hbc_inc >= KEY_BYTES) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_pc < r_dst_capacity) begin
                    case (r_pc[1:0])
                        2'd0:    key_b = r_key[7:0];
                        2'd1:    key_b = r_key[15:8];
                        2'd2:    key_b = r_key[23:16];
                        default: key_b = r_key[31:24];
                    endcase
                    ent.has_byte  = 1'b1;
                    ent.byte_kind = KIND_PAYLOAD;
                    ent.data      = r_sh[7] ? (i_rx_byte ^ key_b) : i_rx_byte;
                    n_pc          = r_pc + CAP_BITS'(1);
                end
            end
            PH_ECHO: begin
                ent.has_byte  = 1'b1;
                ent.byte_kind = KIND_PONG;
                ent.data      = i_rx_byte;
            end
            PH_SKIP: begin
            end
            default: begin
                n_fh = i_rx_byte;
                n_sh = 8'd0;
                if ((i_rx_byte & {4'd0, OPC_MASK_LO}) == {4'd0, OPC_PING}) begin
                    ent.has_byte  = 1'b1;
                    ent.byte_kind = KIND_PONG;
                    ent.data      = PONG_FIRST;
                end
                n_phase = PH_SECOND;
            end
        endcase

        ent.hdr_first  = n_fh;
        ent.hdr_second = n_sh;

        if (i_frame_end) begin
            ent.has_status = 1'b1;
            if (n_phase inside {PH_SECOND, PH_EXTLEN, PH_MASK}) begin
                ent.status = ST_TRUNCATED;
            end else if (n_fh[3:0] == OPC_TEXT || n_fh[3:0] == OPC_BINARY) begin
                ent.status = ST_OK;
                ent.len    = n_len;
            end else if (n_fh[3:0] == OPC_PING) begin
                ent.status = ST_PING;
                ent.len    = n_rc;
            end else if (n_fh[3:0] == OPC_CLOSE) begin
                ent.status = ST_CLOSE;
            end else begin
                ent.status = ST_UNKNOWN;
            end
            n_phase = PH_FIRST;
            n_fh    = 8'd0;
            n_sh    = 8'd0;
            n_len   = 32'd0;
            n_hbc   = 4'd0;
            n_key   = 32'd0;
            n_pc    = '0;
            n_rc    = 32'd0;
        end
    end

    assign o_push  = accept && (ent.has_byte || ent.has_status);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FIRST;
            r_fh           <= 8'd0;
            r_sh           <= 8'd0;
            r_len          <= 32'd0;
            r_hbc          <= 4'd0;
            r_key          <= 32'd0;
            r_pc           <= '0;
            r_rc           <= 32'd0;
            r_dst_capacity <= '1;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_fh    <= n_fh;
                r_sh    <= n_sh;
                r_len   <= n_len;
                r_hbc   <= n_hbc;
                r_key   <= n_key;
                r_pc    <= n_pc;
                r_rc    <= n_rc;
            end
            if (i_cfg_we) begin
                r_dst_capacity <= i_cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/wsd_fifo.sv -----
// Short queue of parsed entries between the front and back ends.
// Depends on wsd_pkg.
`default_nettype none
module wsd_fifo import wsd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/wsd_back.sv -----
// Back end of the deframer: holds one entry and sends its byte result, then
// its status result, on the output channel. Depends on wsd_pkg.
`default_nettype none
module wsd_back import wsd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  wire t_entry i_q_head,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic [31:0] o_declared_length,
    output logic [7:0]  o_header_first,
    output logic [7:0]  o_header_second,
    output logic        o_last_of_frame
);

    t_entry r_cur;
    logic   r_cur_valid;
    logic   r_byte_sent;
    logic   show_byte;
    logic   xfer;
    logic   done;
    logic   load;

    assign show_byte = r_cur.has_byte && !r_byte_sent;
    assign xfer      = r_cur_valid && i_out_ready;
    assign done      = xfer && (!show_byte || !r_cur.has_status);
    assign load      = !r_cur_valid || done;
    assign o_q_pop   = load && !i_q_empty;

    assign o_out_valid       = r_cur_valid;
    assign o_kind            = show_byte ? r_cur.byte_kind : KIND_STATUS;
    assign o_data_byte       = show_byte ? r_cur.data : 8'd0;
    assign o_status          = show_byte ? ST_OK : r_cur.status;
    assign o_declared_length = show_byte ? 32'd0 : r_cur.len;
    assign o_header_first    = r_cur.hdr_first;
    assign o_header_second   = r_cur.hdr_second;
    assign o_last_of_frame   = !show_byte;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_byte_sent <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= !i_q_empty;
                r_byte_sent <= 1'b0;
            end else if (xfer) begin
                r_byte_sent <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/websocket_frame_deframer.sv -----
// WebSocket frame deframer top level: parser front end, two-entry queue, result back end.
// A result passes through the queue and the back end's holding register to the output.
// Input: one byte per cycle while the queue is not full; a byte that ends a frame and also
// yields a payload or pong byte gives two results, so a run of them holds back the input.
// Reset (synchronous, active low) clears the parser, queue and output stage and
// sets dst_capacity to all ones. Depends on wsd_pkg, wsd_front, wsd_fifo, wsd_back.
`default_nettype none
module websocket_frame_deframer import wsd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_BITS-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic                i_frame_end,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_kind,
    output logic [7:0]               o_data_byte,
    output logic [2:0]               o_status,
    output logic [31:0]              o_declared_length,
    output logic [7:0]               o_header_first,
    output logic [7:0]               o_header_second,
    output logic                     o_last_of_frame
);

    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    t_entry q_in;
    t_entry q_head;

    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    wsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    wsd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_head          (q_head),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_status          (o_status),
        .o_declared_length (o_declared_length),
        .o_header_first    (o_header_first),
        .o_header_second   (o_header_second),
        .o_last_of_frame   (o_last_of_frame)
    );

endmodule
`default_nettype wire

// ----- verif/tb_websocket_frame_deframer.sv -----
// Testbench for websocket_frame_deframer: feeds directed and random frames through the
// byte channel with random idles and stalls, and checks every result against a local model.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
`default_nettype none
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int         PIPE_LAT     = 2;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         ITEMS_TARGET = 1550;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  status;
        logic [31:0] dlen;
        logic [7:0]  hf;
        logic [7:0]  hs;
        logic        lastf;
    } t_deframed;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte = '0;
    logic                frame_end = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          kind;
    logic [7:0]          data_byte;
    logic [2:0]          status;
    logic [31:0]         declared_length;
    logic [7:0]          header_first;
    logic [7:0]          header_second;
    logic                last_of_frame;

    // local model state
    t_phase              ph = PH_FIRST;
    logic [7:0]          hdr1 = '0;
    logic [7:0]          hdr2 = '0;
    logic [63:0]         len_acc = '0;
    logic [3:0]          hcnt = '0;
    logic [31:0]         key = '0;
    logic [CAP_BITS-1:0] pcount = '0;
    logic [CAP_BITS-1:0] capacity = '1;
    logic [31:0]         rcount = '0;
    t_deframed           deframed_q[$];

    int  errors = 0;
    int  bytes_sent = 0;
    int  cycle_count = 0;
    bit  tx_calm = 1'b0;
    bit  force_calm = 1'b0;
    int  rx_left = 0;
    bit  rx_on = 1'b0;
    int  rx_hold_req = 0;

    websocket_frame_deframer i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_rx_byte         (rx_byte),
        .i_frame_end       (frame_end),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_kind            (kind),
        .o_data_byte       (data_byte),
        .o_status          (status),
        .o_declared_length (declared_length),
        .o_header_first    (header_first),
        .o_header_second   (header_second),
        .o_last_of_frame   (last_of_frame)
    );

    always #4 clk = ~clk;

    task automatic restart_frame();
        ph = PH_FIRST;
        hdr1 = '0;
        hdr2 = '0;
        len_acc = '0;
        hcnt = '0;
        key = '0;
        pcount = '0;
        rcount = '0;
    endtask

    task automatic push_out(input logic [1:0] k, input logic [7:0] d, input logic [2:0] st,
                            input logic [31:0] dl, input logic lastf);
        t_deframed r;
        r.kind = k;
        r.data = d;
        r.status = st;
        r.dlen = dl;
        r.hf = hdr1;
        r.hs = hdr2;
        r.lastf = lastf;
        deframed_q.push_back(r);
    endtask

    task automatic finish_length();
        hcnt = '0;
        ph = hdr2[7] ? PH_MASK : PH_PAYLOAD;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic e);
        logic [3:0]  opc;
        logic [3:0]  need;
        logic [2:0]  st;
        logic [31:0] dl;
        rcount = rcount + 32'd1;
        case (ph)
            PH_SECOND: begin
                hdr2 = b;
                opc = hdr1[3:0];
                if (opc == OPC_PING) begin
                    push_out(KIND_PONG, b, ST_OK, '0, 1'b0);
                    ph = PH_ECHO;
                end else if (opc == OPC_TEXT || opc == OPC_BINARY) begin
                    if (b[6:0] <= LEN_SHORT_MAX) begin
                        len_acc = 64'(b[6:0]);
                        finish_length();
                    end else begin
                        len_acc = '0;
                        hcnt = '0;
                        ph = PH_EXTLEN;
                    end
                end else begin
                    ph = PH_SKIP;
                end
            end
            PH_EXTLEN: begin
                len_acc = {len_acc[55:0], b};
                hcnt = hcnt + 4'd1;
                need = (hdr2[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                if (hcnt >= need) finish_length();
            end
            PH_MASK: begin
                key = key | (32'(b) << (8 * hcnt[1:0]));
                hcnt = hcnt + 4'd1;
                if (hcnt >= KEY_BYTES) ph = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (pcount < capacity) begin
                    push_out(KIND_PAYLOAD, hdr2[7] ? b ^ 8'(key >> (8 * pcount[1:0])) : b,
                             ST_OK, '0, 1'b0);
                    pcount = pcount + CAP_BITS'(1);
                end
            end
            PH_ECHO: begin
                push_out(KIND_PONG, b, ST_OK, '0, 1'b0);
            end
            PH_SKIP: begin
            end
            default: begin
                hdr1 = b;
                hdr2 = '0;
                if (b[3:0] == OPC_PING) push_out(KIND_PONG, PONG_FIRST, ST_OK, '0, 1'b0);
                ph = PH_SECOND;
            end
        endcase
        if (e) begin
            opc = hdr1[3:0];
            dl = '0;
            if (ph == PH_SECOND || ph == PH_EXTLEN || ph == PH_MASK) begin
                st = ST_TRUNCATED;
            end else if (opc == OPC_TEXT || opc == OPC_BINARY) begin
                st = ST_OK;
                dl = len_acc[31:0];
            end else if (opc == OPC_PING) begin
                st = ST_PING;
                dl = rcount;
            end else if (opc == OPC_CLOSE) begin
                st = ST_CLOSE;
            end else begin
                st = ST_UNKNOWN;
            end
            push_out(KIND_STATUS, 8'h00, st, dl, 1'b1);
            restart_frame();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= e;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        deframe_byte(b, e);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] fbytes[$]);
        tx_calm = force_calm || ($urandom_range(0, 99) < 25);
        foreach (fbytes[i]) send_byte(fbytes[i], i == fbytes.size() - 1);
    endtask

    task automatic send_random_frame(input bit data_only);
        logic [7:0] fq[$];
        logic [3:0] opc;
        logic [6:0] code;
        bit         masked;
        int         n, pick, ext, hlen, cut;
        pick = $urandom_range(0, 99);
        if (!data_only && pick < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) fq.push_back(8'($urandom));
        end else begin
            if (data_only || pick < 62) opc = $urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY;
            else if (pick < 78) opc = OPC_PING;
            else if (pick < 88) opc = OPC_CLOSE;
            else opc = 4'($urandom);
            masked = 1'($urandom);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            pick = $urandom_range(0, 9);
            ext = 0;
            if (pick < 5) begin
                code = 7'(n);
            end else if (pick < 6) begin
                code = 7'($urandom_range(0, LEN_SHORT_MAX));
            end else if (pick < 8) begin
                code = LEN_CODE_16;
                ext = int'(EXT_BYTES_16);
            end else begin
                code = LEN_CODE_64;
                ext = int'(EXT_BYTES_64);
            end
            hlen = 2 + ext + (masked ? int'(KEY_BYTES) : 0);
            fq.push_back({4'($urandom), opc});
            fq.push_back({masked, code});
            repeat (hlen - 2) fq.push_back(8'($urandom));
            repeat (n) fq.push_back(8'($urandom));
            if (!data_only && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, hlen);
                fq = fq[0:cut-1];
            end
        end
        send_frame(fq);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        capacity = v;
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_frames();
        send_frame('{{4'h8, OPC_TEXT}, 8'h00});
        send_frame('{{4'h8, OPC_PING}});
        send_frame('{{4'h8, OPC_CLOSE}, 8'h80});
        send_frame('{8'h00, 8'hFF});
        send_frame('{{4'h8, OPC_BINARY}, {1'b0, LEN_CODE_16}, 8'hFF, 8'hFF});
        send_frame('{{4'h0, OPC_TEXT}, {1'b0, LEN_CODE_64}, 8'h00});
        send_frame('{{4'h8, OPC_TEXT}, 8'h81, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h3C, 8'hC3});
        send_frame('{{4'h8, OPC_PING}, 8'h01, 8'h7E});
        send_frame('{{4'h8, OPC_BINARY}, 8'h80, 8'h11});
        wait_drained();
    endtask

    task automatic test_capacity_limits();
        logic [CAP_BITS-1:0] cap_list[$];
        cap_list = '{'0, 1, 3, 7, 16'h8000, '1};
        cap_list.push_back(CAP_BITS'($urandom));
        cap_list.push_back(CAP_BITS'($urandom_range(0, 12)));
        foreach (cap_list[i]) begin
            write_capacity(cap_list[i]);
            repeat (8) send_random_frame(1'b1);
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        int start;
        wait_drained();
        @(negedge clk);
        rx_hold_req = 300;
        @(posedge clk);
        force_calm = 1'b1;
        start = bytes_sent;
        while (bytes_sent < start + 80) send_random_frame(1'b1);
        force_calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames();
        int frames;
        int r;
        frames = 0;
        while (bytes_sent < ITEMS_TARGET) begin
            if (frames % 40 == 39) begin
                r = $urandom_range(0, 2);
                if (r == 0) write_capacity(CAP_BITS'($urandom_range(0, 12)));
                else if (r == 1) write_capacity('1);
                else write_capacity(CAP_BITS'($urandom));
            end
            send_random_frame(1'b0);
            frames++;
        end
        wait_drained();
    endtask

    // receiver: random ready stretches, plus long hold-offs on request
    always @(posedge clk) begin
        if (rx_hold_req > 0) begin
            rx_left = rx_hold_req;
            rx_on = 1'b0;
            rx_hold_req = 0;
        end else if (rx_left == 0) begin
            rx_on = ($urandom_range(0, 99) < 60);
            if (rx_on) rx_left = $urandom_range(1, 40);
            else if ($urandom_range(0, 99) < 70) rx_left = $urandom_range(1, 2);
            else if ($urandom_range(0, 99) < 85) rx_left = $urandom_range(3, 8);
            else rx_left = $urandom_range(20, 60);
        end
        out_ready <= rx_on;
        rx_left--;
    end

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, fname, want, got);
        end
    endfunction

    // outputs are stable at the falling edge; the transfer happens at the next rising edge
    always @(negedge clk) begin
        t_deframed w;
        if (rst_n && out_valid && out_ready) begin
            if (deframed_q.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer: expected none actual kind %0d data %0h",
                         $time, kind, data_byte);
            end else begin
                w = deframed_q.pop_front();
                check_field("kind", 32'(w.kind), 32'(kind));
                check_field("data_byte", 32'(w.data), 32'(data_byte));
                check_field("status", 32'(w.status), 32'(status));
                check_field("declared_length", w.dlen, declared_length);
                check_field("header_first", 32'(w.hf), 32'(header_first));
                check_field("header_second", 32'(w.hs), 32'(header_second));
                check_field("last_of_frame", 32'(w.lastf), 32'(last_of_frame));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_capacity_limits();
        test_output_stall();
        test_random_frames();
        wait_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
